>>> rtl/lpm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpm_pkg: shared types and constants for the longest-prefix-match lookup
// Field widths, item encodings, controller states and the command/status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package lpm_pkg;

	localparam int ADDR_W    = 32;
	localparam int IFACE_W   = 4;
	localparam int SLOT_W    = 5;
	localparam int S_DATA_W  = 112;  // 106 bits of fields, padded to bytes
	localparam int M_DATA_W  = 40;   // 36 bits of fields, padded to bytes

	// item kind carried in s_tuser
	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	// one route table entry as stored in the table memory
	typedef struct packed {
		logic               valid;
		logic [IFACE_W-1:0] iface;
		logic [ADDR_W-1:0]  mask;
		logic [ADDR_W-1:0]  dest;
	} route_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clr_wr;      // write an empty entry at the scan index
		logic ent_wr;      // store the entry of the input beat
		logic scan_start;  // latch lookup address, clear the best match
		logic rd;          // read the entry at the scan index
		logic idx_inc;
		logic idx_clr;
		logic load_out;    // move the best match into the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic idx_last;
		logic out_busy;
	} sts_t;

endpackage

`default_nettype wire

>>> rtl/lpm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpm_ctrl: sequencing controller
// Runs the clearing pass after reset, takes input beats, steps the table
// scan for lookups and hands the result to the output register.
// ----------------------------------------------------------------------------
module lpm_ctrl
	import lpm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  wire logic s_tuser,   // [0] op
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.idx_last) begin
					cmd.idx_clr = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (op_t'(s_tuser) == OP_LOOKUP) begin
						cmd.scan_start = 1'b1;
						state_d        = ST_SCAN;
					end else begin
						cmd.ent_wr = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.rd = 1'b1;
				if (sts.idx_last) begin
					cmd.idx_clr = 1'b1;
					state_d     = ST_DRAIN;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			// last entry read is compared in this cycle
			ST_DRAIN: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/lpm_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpm_dpath: route table datapath
// Table memory, scan index, registered read, match compare, best-match
// registers and the output register.
// ----------------------------------------------------------------------------
module lpm_dpath
	import lpm_pkg::*;
#(
	parameter int TABLE_ENTRIES = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cmd_t                cmd,
	output sts_t                     sts,
	input  wire logic [S_DATA_W-1:0] s_tdata,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata,
	output logic                     m_tuser
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	// input beat fields
	logic [SLOT_W-1:0]  entry_index;
	logic [ADDR_W-1:0]  entry_dest;
	logic [ADDR_W-1:0]  entry_mask;
	logic [IFACE_W-1:0] entry_iface;
	logic               entry_valid;
	logic [ADDR_W-1:0]  lookup_addr;

	assign entry_index = s_tdata[4:0];
	assign entry_dest  = s_tdata[36:5];
	assign entry_mask  = s_tdata[68:37];
	assign entry_iface = s_tdata[72:69];
	assign entry_valid = s_tdata[73];
	assign lookup_addr = s_tdata[105:74];

	route_t             mem [TABLE_ENTRIES];
	logic [IDX_W-1:0]   idx_q;
	route_t             rd_s1;
	logic               rd_vld_s1;
	logic [ADDR_W-1:0]  addr_q;
	logic               hit_q;
	logic [ADDR_W-1:0]  mask_q;
	logic [IFACE_W-1:0] iface_q;
	logic               out_vld_q;
	logic               out_found_q;
	logic [ADDR_W-1:0]  out_mask_q;
	logic [IFACE_W-1:0] out_iface_q;

	logic [31:0]        slot_ext;
	logic               slot_ok;
	logic [IDX_W-1:0]   wr_addr;
	route_t             wr_ent;
	logic               match;
	logic               take;

	// write address; slots past the table are dropped
	assign slot_ext = 32'(entry_index);
	assign slot_ok  = slot_ext < 32'(TABLE_ENTRIES);
	assign wr_addr  = slot_ext[IDX_W-1:0];

	always_comb begin
		wr_ent.valid = entry_valid;
		wr_ent.iface = entry_iface;
		wr_ent.mask  = entry_mask;
		wr_ent.dest  = entry_dest;
	end

	// table write port
	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			mem[idx_q] <= '0;
		end else if (cmd.ent_wr && slot_ok) begin
			mem[wr_addr] <= wr_ent;
		end
	end

	// table read port, registered
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_s1 <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd;
		end
	end

	// scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	assign sts.idx_last = (idx_q == IDX_W'(TABLE_ENTRIES - 1));
	assign sts.out_busy = out_vld_q && !m_tready;

	// match and priority: larger mask wins, earlier entry keeps a tie
	assign match = rd_vld_s1 && rd_s1.valid && ((addr_q & rd_s1.mask) == rd_s1.dest);
	assign take  = match && (!hit_q || (rd_s1.mask > mask_q));

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			addr_q <= lookup_addr;
		end
	end

	// best match so far
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.scan_start) begin
			hit_q <= 1'b0;
		end else if (take) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			mask_q  <= '0;
			iface_q <= '0;
		end else if (take) begin
			mask_q  <= rd_s1.mask;
			iface_q <= rd_s1.iface;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_found_q <= hit_q;
			out_mask_q  <= mask_q;
			out_iface_q <= iface_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_found_q;
	assign m_tdata  = {4'b0000, out_mask_q, out_iface_q};

endmodule

`default_nettype wire

>>> rtl/longest_prefix_match_lookup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// longest_prefix_match_lookup: IPv4 route table with longest-prefix match
// Write beats store route entries; lookup beats scan the table and return
// the longest matching route.
// ----------------------------------------------------------------------------
// A write beat (op = 0) is stored in the table as it is accepted and gives
// no result. A lookup beat (op = 1) reads the table memory one entry per
// cycle through its single read port: the scan reads every entry, the drain
// state compares the last entry read and the output state then loads the
// result into the output register. The next beat is taken once the result
// has moved into the output register; a result still waiting in that
// register holds the next lookup back until it is taken. After reset a
// clearing pass empties the table, and no beat is accepted until it is
// done. The result carries found in m_tuser; with no match the interface
// and mask are zero. A 0.0.0.0/0 route matches every address.
// ----------------------------------------------------------------------------
module longest_prefix_match_lookup
	import lpm_pkg::*;
#(
	parameter int TABLE_ENTRIES = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// entry_index, entry_dest, entry_mask, entry_iface, entry_valid, lookup_addr
	input  wire logic [S_DATA_W-1:0] s_tdata,
	input  wire logic                s_tuser,   // op
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata,   // out_iface, best_mask
	output logic                     m_tuser    // found
);

	cmd_t cmd;
	sts_t sts;

	lpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	lpm_dpath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire
